// File: hw/rtl/fmtg_pkg.sv
package fmtg_pkg;

    localparam int MAX_VEHICLES = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;
    localparam int NMAX         = (MAX_VEHICLES < 16) ? MAX_VEHICLES : 16;
    localparam int K_W          = $clog2(CORDIC_STEPS);
    localparam int CS_W         = 32;
    localparam int FR_W         = 22;
    localparam int Z_W          = 34;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = $clog2(QDEPTH);

    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [53:0] HALF_Q30 = 54'sd536870912;

    localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81
    };

    // whole part and remainder of 65536 / n, indexed by n - 1
    localparam logic [16:0] QSTEP [16] = '{
        17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922,
        17'd9362, 17'd8192, 17'd7281, 17'd6553, 17'd5957, 17'd5461,
        17'd5041, 17'd4681, 17'd4369, 17'd4096
    };
    localparam logic [4:0] RSTEP [16] = '{
        5'd0, 5'd0, 5'd1, 5'd0, 5'd1, 5'd4, 5'd2, 5'd0,
        5'd7, 5'd6, 5'd9, 5'd4, 5'd3, 5'd2, 5'd1, 5'd0
    };

    typedef logic signed [31:0]     pos_t;
    typedef logic signed [CS_W-1:0] cs_t;
    typedef logic signed [FR_W-1:0] fr_t;

    typedef enum logic [1:0] {PAT_LINE, PAT_V, PAT_CIRCLE, PAT_DIAMOND} pat_t;

    typedef enum logic [2:0] {
        CFG_PATTERN, CFG_COUNT, CFG_SPACING, CFG_ALT, CFG_VANGLE
    } cfg_idx_t;

    typedef struct packed {
        pat_t               pattern;
        logic [4:0]         count;
        logic [15:0]        spacing;
        logic signed [15:0] alt_step;
        logic [14:0]        v_angle;
    } cfg_t;

    typedef struct packed {
        pos_t        px;
        pos_t        py;
        pos_t        pz;
        logic [15:0] hd;
        cs_t         hc;
        cs_t         hs;
        cs_t         vc;
        cs_t         vs;
    } qent_t;

    typedef enum logic [0:0] {C_IDLE, C_RUN} cordic_state_t;
    typedef enum logic [1:0] {F_IDLE, F_TRIG, F_PUSH} front_state_t;
    typedef enum logic [2:0] {
        B_IDLE, B_PREP, B_RUN, B_CSTART, B_CWAIT, B_CISSUE
    } back_state_t;

    function automatic logic [31:0] atan_at(input logic [4:0] k);
        return ATAN_TAB[k];
    endfunction

    function automatic pos_t sat32(input logic signed [Z_W-1:0] v);
        if (v > 34'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// File: hw/rtl/fmtg_intf.sv
interface fmtg_pose_if;
    import fmtg_pkg::*;
    logic        valid;
    logic        ready;
    pos_t        pos_x;
    pos_t        pos_y;
    pos_t        pos_z;
    logic signed [15:0] heading;

    modport source (output valid, pos_x, pos_y, pos_z, heading, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, heading, output ready);
endinterface

interface fmtg_target_if;
    import fmtg_pkg::*;
    logic        valid;
    logic        ready;
    logic [3:0]  vehicle_index;
    pos_t        target_x;
    pos_t        target_y;
    pos_t        target_z;
    logic signed [15:0] target_yaw;
    logic        last;

    modport source (output valid, vehicle_index, target_x, target_y, target_z,
                    target_yaw, last, input ready);
    modport sink (input valid, vehicle_index, target_x, target_y, target_z,
                  target_yaw, last, output ready);
endinterface

// File: hw/rtl/fmtg_cordic.sv
module fmtg_cordic (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [15:0]    angle,
    output logic           busy,
    output logic           done,
    output fmtg_pkg::cs_t  cos_q,
    output fmtg_pkg::cs_t  sin_q
);
    import fmtg_pkg::*;

    cordic_state_t      state_reg, state_next;
    logic [K_W-1:0]     k_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic               flip_reg;
    logic               done_reg;
    cs_t                cos_reg, sin_reg;

    logic [31:0]        a_in;
    logic               flip_in;
    logic signed [33:0] xs, ys, x_step, y_step;
    logic signed [32:0] z_step, at;
    logic               last_step;

    // fold the second and third quadrant by half a turn
    assign a_in    = {angle, 16'b0};
    assign flip_in = a_in[31] ^ a_in[30];

    assign xs        = x_reg >>> k_reg;
    assign ys        = y_reg >>> k_reg;
    assign at        = signed'({1'b0, atan_at(5'(k_reg))});
    assign last_step = (k_reg == K_W'(CORDIC_STEPS - 1));

    // rotate one micro-step toward zero residual angle
    always_comb
    begin
        if (!z_reg[32])
        begin
            x_step = x_reg - ys;
            y_step = y_reg + xs;
            z_step = z_reg - at;
        end
        else
        begin
            x_step = x_reg + ys;
            y_step = y_reg - xs;
            z_step = z_reg + at;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE: if (start) state_next = C_RUN;
            C_RUN:  if (last_step) state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy  = (state_reg == C_RUN);
        done  = done_reg;
        cos_q = cos_reg;
        sin_q = sin_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == C_RUN) && last_step;
            if (state_reg == C_IDLE)
                k_reg <= '0;
            else
                k_reg <= k_reg + K_W'(1);
        end
    end

    // load the start vector, then iterate
    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && start)
        begin
            x_reg    <= GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= signed'({flip_in ? ~a_in[31] : a_in[31],
                                 flip_in ? ~a_in[31] : a_in[31], a_in[30:0]});
            flip_reg <= flip_in;
        end
        else if (state_reg == C_RUN)
        begin
            x_reg <= x_step;
            y_reg <= y_step;
            z_reg <= z_step;
            if (last_step)
            begin
                cos_reg <= flip_reg ? CS_W'(-x_step) : CS_W'(x_step);
                sin_reg <= flip_reg ? CS_W'(-y_step) : CS_W'(y_step);
            end
        end
    end

endmodule

// File: hw/rtl/fmtg_front.sv
module fmtg_front (
    input  logic            clk,
    input  logic            rst_n,
    fmtg_pose_if.sink       pose,
    input  logic [14:0]     v_angle,
    output logic            push,
    output fmtg_pkg::qent_t push_data,
    input  logic            full
);
    import fmtg_pkg::*;

    front_state_t state_reg, state_next;
    logic         hold_valid_reg;
    pos_t         hold_px_reg, hold_py_reg, hold_pz_reg;
    logic [15:0]  hold_hd_reg;
    pos_t         work_px_reg, work_py_reg, work_pz_reg;
    logic [15:0]  work_hd_reg;

    logic accept, start;
    logic h_busy, h_done, v_busy, v_done;
    cs_t  hc, hs, vc, vs;

    assign pose.ready = !hold_valid_reg;
    assign accept     = pose.valid && !hold_valid_reg;
    assign start      = (state_reg == F_IDLE) && hold_valid_reg;

    fmtg_cordic u_head (
        .clk(clk), .rst_n(rst_n), .start(start), .angle(hold_hd_reg),
        .busy(h_busy), .done(h_done), .cos_q(hc), .sin_q(hs)
    );

    fmtg_cordic u_vang (
        .clk(clk), .rst_n(rst_n), .start(start), .angle({1'b0, v_angle}),
        .busy(v_busy), .done(v_done), .cos_q(vc), .sin_q(vs)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (start) state_next = F_TRIG;
            F_TRIG: if (h_done && v_done) state_next = F_PUSH;
            F_PUSH: if (!full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        push = (state_reg == F_PUSH) && !h_busy && !v_busy;
        push_data.px = work_px_reg;
        push_data.py = work_py_reg;
        push_data.pz = work_pz_reg;
        push_data.hd = work_hd_reg;
        push_data.hc = hc;
        push_data.hs = hs;
        push_data.vc = vc;
        push_data.vs = vs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                hold_valid_reg <= 1'b1;
            else if (start)
                hold_valid_reg <= 1'b0;
        end
    end

    // hold the incoming word, then move it to the work slot
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_px_reg <= pose.pos_x;
            hold_py_reg <= pose.pos_y;
            hold_pz_reg <= pose.pos_z;
            hold_hd_reg <= pose.heading;
        end
        if (start)
        begin
            work_px_reg <= hold_px_reg;
            work_py_reg <= hold_py_reg;
            work_pz_reg <= hold_pz_reg;
            work_hd_reg <= hold_hd_reg;
        end
    end

endmodule

// File: hw/rtl/fmtg_queue.sv
module fmtg_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fmtg_pkg::qent_t wr_data,
    output logic            full,
    input  logic            pop,
    output fmtg_pkg::qent_t rd_data,
    output logic            empty
);
    import fmtg_pkg::*;

    qent_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (QPTR_W + 1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (QPTR_W + 1)'(1);
        end
    end

    // store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: hw/rtl/fmtg_back.sv
module fmtg_back (
    input  logic            clk,
    input  logic            rst_n,
    input  fmtg_pkg::cfg_t  cfg,
    input  fmtg_pkg::qent_t q_data,
    input  logic            q_empty,
    output logic            q_pop,
    fmtg_target_if.source   target
);
    import fmtg_pkg::*;

    back_state_t        state_reg, state_next;
    qent_t              pose_reg;
    logic [4:0]         n_reg;
    logic [3:0]         i_reg;
    logic [16:0]        ang_reg;
    logic [4:0]         rem_reg;
    logic signed [48:0] pv_reg, qv_reg;
    logic [15:0]        m_reg;
    cs_t                ccos_reg, csin_reg;

    // stage A: offsets chosen
    logic               a_valid_reg;
    logic [3:0]         a_idx_reg;
    fr_t                a_f_reg, a_r_reg;
    cs_t                a_c_reg, a_s_reg;
    pos_t               a_px_reg, a_py_reg;
    logic signed [Z_W-1:0] a_z_reg;
    logic [15:0]        a_yaw_reg;
    logic               a_last_reg;
    // stage B: products
    logic               b_valid_reg;
    logic [3:0]         b_idx_reg;
    logic signed [53:0] b_fc_reg, b_rs_reg, b_fs_reg, b_rc_reg;
    pos_t               b_px_reg, b_py_reg;
    logic signed [Z_W-1:0] b_z_reg;
    logic [15:0]        b_yaw_reg;
    logic               b_last_reg;
    // output word
    logic               o_valid_reg;
    logic [3:0]         o_idx_reg;
    pos_t               o_x_reg, o_y_reg, o_z_reg;
    logic [15:0]        o_yaw_reg;
    logic               o_last_reg;

    logic        adv, issue, is_last, is_circle;
    logic [4:0]  n_in;
    logic [3:0]  nidx, rank;
    logic [2:0]  k;
    logic signed [4:0]  rank_s;
    logic signed [16:0] s17;
    logic [19:0] lin, ks, hh;
    logic signed [53:0] pf, pr;
    logic signed [53:0] vf, vr;
    fr_t         f_v, r_v;
    logic [32:0] mprod;
    logic [5:0]  rem_sum;
    logic        carry;
    logic signed [20:0] ialt;
    logic        use_alt;
    logic signed [Z_W-1:0] zsum;
    logic        c_busy, c_done;
    cs_t         c_cos, c_sin;
    logic signed [54:0] sx, sy;
    logic signed [Z_W-1:0] tx, ty;

    assign adv       = !o_valid_reg || target.ready;
    assign is_circle = (cfg.pattern == PAT_CIRCLE);
    assign is_last   = (({1'b0, i_reg} + 5'd1) == n_reg);
    assign issue     = ((state_reg == B_RUN) || (state_reg == B_CISSUE)) && adv;
    assign q_pop     = (state_reg == B_IDLE) && !q_empty;
    assign nidx      = 4'(n_reg - 5'd1);

    // clamp the count to one through the vehicle limit
    always_comb
    begin
        if (cfg.count == 5'd0)
            n_in = 5'd1;
        else if (cfg.count > 5'(NMAX))
            n_in = 5'(NMAX);
        else
            n_in = cfg.count;
    end

    fmtg_cordic u_circ (
        .clk(clk), .rst_n(rst_n), .start(state_reg == B_CSTART),
        .angle(ang_reg[15:0]), .busy(c_busy), .done(c_done),
        .cos_q(c_cos), .sin_q(c_sin)
    );

    // per-pose constants
    assign s17   = signed'({1'b0, cfg.spacing});
    assign mprod = 33'(cfg.spacing) * 33'd45875 + 33'd32768;

    // rank and side of the current vehicle
    assign rank   = 4'(({1'b0, i_reg} + 5'd1) >> 1);
    assign rank_s = signed'({1'b0, rank});
    assign k      = i_reg[3:1];
    assign lin    = 20'(rank) * 20'(cfg.spacing);
    assign ks     = 20'(k) * 20'(cfg.spacing);
    assign hh     = 20'((21'(ks) + 21'd1) >> 1);

    // arm offsets of the V
    assign pf  = rank_s * pv_reg;
    assign pr  = rank_s * qv_reg;
    assign vf  = (pf + HALF_Q30) >>> 30;
    assign vr  = (pr + HALF_Q30) >>> 30;
    assign f_v = FR_W'(-vf);
    assign r_v = FR_W'(vr);

    // altitude ladder
    assign use_alt = (cfg.alt_step >= 16'sd3) || (cfg.alt_step <= -16'sd3);
    assign ialt    = signed'({1'b0, i_reg}) * cfg.alt_step;
    assign zsum    = use_alt ? ({{2{pose_reg.pz[31]}}, pose_reg.pz}
                                - {{(Z_W - 21){ialt[20]}}, ialt})
                             : {{2{pose_reg.pz[31]}}, pose_reg.pz};

    // step the circle angle by 65536 / n
    assign rem_sum = {1'b0, rem_reg} + {1'b0, RSTEP[nidx]};
    assign carry   = (rem_sum >= {1'b0, n_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:   if (!q_empty) state_next = B_PREP;
            B_PREP:   state_next = is_circle ? B_CSTART : B_RUN;
            B_RUN:    if (adv && is_last) state_next = B_IDLE;
            B_CSTART: state_next = B_CWAIT;
            B_CWAIT:  if (c_done && !c_busy) state_next = B_CISSUE;
            B_CISSUE:
                if (adv)
                    state_next = is_last ? B_IDLE : B_CSTART;
            default:  state_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        target.valid         = o_valid_reg;
        target.vehicle_index = o_idx_reg;
        target.target_x      = o_x_reg;
        target.target_y      = o_y_reg;
        target.target_z      = o_z_reg;
        target.target_yaw    = o_yaw_reg;
        target.last          = o_last_reg;
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (adv)
            begin
                a_valid_reg <= issue;
                b_valid_reg <= a_valid_reg;
                o_valid_reg <= b_valid_reg;
            end
        end
    end

    // per-pose and per-vehicle state
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pose_reg <= q_data;
            n_reg    <= n_in;
            i_reg    <= '0;
            ang_reg  <= '0;
            rem_reg  <= '0;
        end
        if (state_reg == B_PREP)
        begin
            pv_reg <= s17 * pose_reg.vc;
            qv_reg <= s17 * pose_reg.vs;
            m_reg  <= mprod[31:16];
        end
        if (c_done)
        begin
            ccos_reg <= c_cos;
            csin_reg <= c_sin;
        end
        if (issue)
        begin
            i_reg   <= i_reg + 4'd1;
            ang_reg <= ang_reg + QSTEP[nidx] + 17'(carry);
            rem_reg <= carry ? 5'(rem_sum - {1'b0, n_reg}) : rem_sum[4:0];
        end
    end

    // choose forward and right offsets for this vehicle
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_idx_reg  <= i_reg;
            a_px_reg   <= pose_reg.px;
            a_py_reg   <= pose_reg.py;
            a_z_reg    <= zsum;
            a_last_reg <= is_last;
            a_c_reg    <= is_circle ? ccos_reg : pose_reg.hc;
            a_s_reg    <= is_circle ? csin_reg : pose_reg.hs;
            a_yaw_reg  <= is_circle ? (ang_reg[15:0] + 16'h8000) : pose_reg.hd;
            unique case (cfg.pattern)
                PAT_LINE:
                begin
                    a_f_reg <= '0;
                    a_r_reg <= i_reg[0] ? fr_t'({2'b0, lin}) : -fr_t'({2'b0, lin});
                end
                PAT_V:
                begin
                    a_f_reg <= f_v;
                    a_r_reg <= i_reg[0] ? r_v : -r_v;
                end
                PAT_CIRCLE:
                begin
                    a_f_reg <= fr_t'({6'b0, cfg.spacing});
                    a_r_reg <= '0;
                end
                PAT_DIAMOND:
                begin
                    priority if (i_reg == 4'd0)
                    begin
                        a_f_reg <= '0;
                        a_r_reg <= '0;
                    end
                    else if (i_reg == 4'd1)
                    begin
                        a_f_reg <= -fr_t'({6'b0, cfg.spacing});
                        a_r_reg <= -fr_t'({6'b0, m_reg});
                    end
                    else if (i_reg == 4'd2)
                    begin
                        a_f_reg <= -fr_t'({6'b0, cfg.spacing});
                        a_r_reg <= fr_t'({6'b0, m_reg});
                    end
                    else if (i_reg == 4'd3)
                    begin
                        a_f_reg <= -fr_t'({5'b0, cfg.spacing, 1'b0});
                        a_r_reg <= '0;
                    end
                    else
                    begin
                        a_f_reg <= -fr_t'({2'b0, ks});
                        a_r_reg <= i_reg[0] ? fr_t'({2'b0, hh}) : -fr_t'({2'b0, hh});
                    end
                end
                default:
                begin
                    a_f_reg <= '0;
                    a_r_reg <= '0;
                end
            endcase
        end
    end

    // rotate the offset by the heading, or by the vehicle's angle for the circle
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_fc_reg   <= a_f_reg * a_c_reg;
            b_rs_reg   <= a_r_reg * a_s_reg;
            b_fs_reg   <= a_f_reg * a_s_reg;
            b_rc_reg   <= a_r_reg * a_c_reg;
            b_idx_reg  <= a_idx_reg;
            b_px_reg   <= a_px_reg;
            b_py_reg   <= a_py_reg;
            b_z_reg    <= a_z_reg;
            b_yaw_reg  <= a_yaw_reg;
            b_last_reg <= a_last_reg;
        end
    end

    // round, add to the leader position and saturate
    assign sx = ($signed({b_fc_reg[53], b_fc_reg}) + $signed({b_rs_reg[53], b_rs_reg})
                 + 55'sd536870912) >>> 30;
    assign sy = ($signed({b_fs_reg[53], b_fs_reg}) - $signed({b_rc_reg[53], b_rc_reg})
                 + 55'sd536870912) >>> 30;
    assign tx = {{2{b_px_reg[31]}}, b_px_reg} + Z_W'(sx);
    assign ty = {{2{b_py_reg[31]}}, b_py_reg} + Z_W'(sy);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_idx_reg  <= b_idx_reg;
            o_x_reg    <= sat32(tx);
            o_y_reg    <= sat32(ty);
            o_z_reg    <= sat32(b_z_reg);
            o_yaw_reg  <= b_yaw_reg;
            o_last_reg <= b_last_reg;
        end
    end

endmodule

// File: hw/rtl/formation_target_generator.sv
// Flow: the front runs each pose through two 16-step CORDIC units and can hold
// the next pose meanwhile; the back pops a pose and prepares it in a setup state,
// then emits one target per cycle while the target side is ready, or for the
// circle waits for each vehicle's angle to finish its own CORDIC run.
// Reset: rst_n is asynchronous, active low; it empties the queue and pipeline
// and returns the registers to line, 4 vehicles, 5 m spacing, no step, 30 deg.
module formation_target_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    fmtg_pose_if.sink   pose,
    fmtg_target_if.source target
);
    import fmtg_pkg::*;

    cfg_t  cfg_reg;
    logic  push, full, pop, empty;
    qent_t push_data, rd_data;

    // write the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern  <= PAT_LINE;
            cfg_reg.count    <= 5'd4;
            cfg_reg.spacing  <= 16'd1280;
            cfg_reg.alt_step <= '0;
            cfg_reg.v_angle  <= 15'd5461;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN: cfg_reg.pattern  <= pat_t'(cfg_data[1:0]);
                CFG_COUNT:   cfg_reg.count    <= cfg_data[4:0];
                CFG_SPACING: cfg_reg.spacing  <= cfg_data;
                CFG_ALT:     cfg_reg.alt_step <= signed'(cfg_data);
                CFG_VANGLE:  cfg_reg.v_angle  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    fmtg_front u_front (
        .clk(clk), .rst_n(rst_n), .pose(pose), .v_angle(cfg_reg.v_angle),
        .push(push), .push_data(push_data), .full(full)
    );

    fmtg_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .wr_data(push_data),
        .full(full), .pop(pop), .rd_data(rd_data), .empty(empty)
    );

    fmtg_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .q_data(rd_data),
        .q_empty(empty), .q_pop(pop), .target(target)
    );

endmodule

// File: hw/rtl/fmtg_checker.sv
module fmtg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  out_index,
    input logic        out_last,
    input logic [31:0] out_x
);
    logic       in_acc, out_acc;
    logic [3:0] pend_reg;
    logic [3:0] prev_idx_reg;
    logic       first_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // track poses in flight and the index of the last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= '0;
            prev_idx_reg <= '0;
            first_reg    <= 1'b1;
        end
        else
        begin
            if (in_acc && !(out_acc && out_last))
                pend_reg <= pend_reg + 4'd1;
            else if (!in_acc && out_acc && out_last)
                pend_reg <= pend_reg - 4'd1;
            if (out_acc)
            begin
                prev_idx_reg <= out_index;
                first_reg    <= out_last;
            end
        end
    end

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 4'd0))
        else $error("target word without an accepted pose");

    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && first_reg) |-> (out_index == 4'd0))
        else $error("pose does not start at vehicle 0");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && !first_reg) |-> (out_index == prev_idx_reg + 4'd1))
        else $error("vehicle index skipped or repeated");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_index)
                                       && $stable(out_x) && $stable(out_last)))
        else $error("stalled target word changed");

endmodule

bind formation_target_generator fmtg_checker u_fmtg_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(pose.valid), .in_ready(pose.ready),
    .out_valid(target.valid), .out_ready(target.ready),
    .out_index(target.vehicle_index), .out_last(target.last),
    .out_x(target.target_x)
);
